// ===== rtl/cfla_pkg.sv =====
// cfla_pkg: shared types, codes and constants of the chunked free-list allocator
// used by every module under rtl/, no dependencies of its own
package cfla_pkg;

	// default sizing, used as the defaults of the top level's parameters
	localparam int NUM_CHUNKS_DEF       = 8;
	localparam int BLOCKS_PER_CHUNK_DEF = 255;
	localparam int LINKS_PER_CHUNK      = 256;

	// fixed field widths of the request and response beats
	localparam int BLK_W    = 8;
	localparam int CHUNK_W  = 3;
	localparam int STATUS_W = 2;
	localparam int OFF_W    = 19;
	localparam int CNT_W    = 8;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE = '0;
	localparam logic [BLK_W-1:0]     BLOCK_SIZE_RST = 8'd16;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic init_wr;
		logic accept;
		logic finish;
	} cfla_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;
	} cfla_sts_t;

endpackage

// ===== rtl/cfla_ctrl.sv =====
// cfla_ctrl: sequencer of the allocator (link store init walk, accept, finish)
// depends on cfla_pkg for the command and status structs
module cfla_ctrl
	import cfla_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	output cfla_cmd_t cmd,
	input  cfla_sts_t sts
);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// handshake and commands
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.init_wr = (state_q == S_INIT);
	assign cmd.accept  = in_valid && (state_q == S_IDLE);
	assign cmd.finish  = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// state and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (sts.init_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd.accept) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.finish) state_q <= S_IDLE;
				end
				default: state_q <= S_INIT;
			endcase

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/cfla_dpath.sv =====
// cfla_dpath: link store, per-chunk heads and counts, chunk choice and response register
// depends on cfla_pkg; driven by cfla_ctrl through cfla_cmd_t
module cfla_dpath
	import cfla_pkg::*;
#(
	parameter int NUM_CHUNKS       = NUM_CHUNKS_DEF,
	parameter int BLOCKS_PER_CHUNK = BLOCKS_PER_CHUNK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfla_cmd_t           cmd,
	output cfla_sts_t           sts,
	input  logic                opcode,
	input  logic [CHUNK_W-1:0]  chunk_sel,
	input  logic [BLK_W-1:0]    block_sel,
	input  logic [BLK_W-1:0]    block_size,
	output logic [STATUS_W-1:0] status,
	output logic [CHUNK_W-1:0]  chunk_granted,
	output logic [BLK_W-1:0]    block_granted,
	output logic [OFF_W-1:0]    byte_offset,
	output logic [CNT_W-1:0]    chunk_free_count
);

	localparam int CW    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int NW    = $clog2(NUM_CHUNKS + 1);
	localparam int AW    = CW + BLK_W;
	localparam int DEPTH = NUM_CHUNKS * LINKS_PER_CHUNK;
	localparam int IDX_W = $clog2(NUM_CHUNKS * BLOCKS_PER_CHUNK);
	localparam int PW    = IDX_W + BLK_W;

	// chunk state
	logic [CNT_W-1:0] count_q [NUM_CHUNKS];
	logic [BLK_W-1:0] head_q  [NUM_CHUNKS];
	logic [NW-1:0]    active_q;
	logic [CW-1:0]    alloc_q;
	logic             alloc_v_q;

	// link store and init walk
	logic [BLK_W-1:0] mem [DEPTH];
	logic [BLK_W-1:0] rdata_q;
	logic [AW-1:0]    init_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [BLK_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;

	// request stage
	logic             op_alloc_s1;
	logic             ok_s1;
	status_t          st_s1;
	logic [CW-1:0]    c_s1;
	logic [BLK_W-1:0] b_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic [IDX_W-1:0] idx_s1;

	// response register
	status_t          out_st_q;
	logic [CHUNK_W-1:0] out_c_q;
	logic [BLK_W-1:0] out_b_q;
	logic [OFF_W-1:0] out_off_q;
	logic [CNT_W-1:0] out_cnt_q;

	// decision signals
	logic [NUM_CHUNKS-1:0] nz;
	logic [NUM_CHUNKS-1:0] act;
	logic             scan_found;
	logic [CW-1:0]    scan_idx;
	logic             alloc_hit;
	logic             can_grow;
	logic             is_alloc;
	logic [CW-1:0]    sel_c;
	logic [CNT_W-1:0] cur_cnt;
	logic [BLK_W-1:0] cur_head;
	logic             free_bad;
	logic             ok;
	status_t          st;
	logic [BLK_W-1:0] gb;
	logic [CNT_W-1:0] new_cnt;
	logic [IDX_W-1:0] idx;
	logic [PW-1:0]    prod;

	assign sts.init_last = (init_q == AW'(DEPTH - 1));
	assign is_alloc      = (opcode == OP_ALLOC);

	// per-chunk flags: has free blocks, is active
	always_comb begin
		for (int i = 0; i < NUM_CHUNKS; i++) begin
			nz[i]  = (count_q[i] != '0);
			act[i] = (NW'(i) < active_q);
		end
	end

	// first active chunk with a free block
	always_comb begin
		scan_found = 1'b0;
		scan_idx   = '0;
		for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
			if (nz[i] && act[i]) begin
				scan_found = 1'b1;
				scan_idx   = CW'(i);
			end
		end
	end

	assign alloc_hit = alloc_v_q && nz[alloc_q];
	assign can_grow  = (active_q < NW'(NUM_CHUNKS));

	// chunk the request works on
	always_comb begin
		if (is_alloc) begin
			if (alloc_hit) begin
				sel_c = alloc_q;
			end else if (scan_found) begin
				sel_c = scan_idx;
			end else begin
				sel_c = CW'(active_q);
			end
		end else begin
			sel_c = CW'(chunk_sel);
		end
	end

	// head and count of the chosen chunk, zero when out of range
	always_comb begin
		cur_cnt  = '0;
		cur_head = '0;
		for (int i = 0; i < NUM_CHUNKS; i++) begin
			if (CW'(i) == sel_c) begin
				cur_cnt  = count_q[i];
				cur_head = head_q[i];
			end
		end
	end

	// status, granted block and updated count
	always_comb begin
		free_bad = (int'(chunk_sel) >= NUM_CHUNKS) || (int'(chunk_sel) >= int'(active_q))
		        || (int'(block_sel) >= BLOCKS_PER_CHUNK)
		        || (cur_cnt >= CNT_W'(BLOCKS_PER_CHUNK));
		if (is_alloc) begin
			ok      = alloc_hit || scan_found || can_grow;
			st      = ok ? ST_OK : ST_NO_SPACE;
			gb      = cur_head;
			new_cnt = cur_cnt - CNT_W'(1);
		end else begin
			ok      = !free_bad;
			st      = ok ? ST_OK : ST_BAD_FREE;
			gb      = block_sel;
			new_cnt = cur_cnt + CNT_W'(1);
		end
		idx = IDX_W'(sel_c) * IDX_W'(BLOCKS_PER_CHUNK) + IDX_W'(gb);
	end

	// link store ports: init walk, push on free, head link read on allocate
	always_comb begin
		if (cmd.init_wr) begin
			mem_we    = 1'b1;
			mem_waddr = init_q;
			mem_wdata = init_q[BLK_W-1:0] + BLK_W'(1);
		end else begin
			mem_we    = cmd.accept && !is_alloc && ok;
			mem_waddr = {sel_c, block_sel};
			mem_wdata = cur_head;
		end
		mem_re    = cmd.accept && is_alloc && ok;
		mem_raddr = {sel_c, cur_head};
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// init walk address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (cmd.init_wr && !sts.init_last) begin
			init_q <= init_q + AW'(1);
		end
	end

	// chunk state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHUNKS; i++) begin
				count_q[i] <= CNT_W'(BLOCKS_PER_CHUNK);
				head_q[i]  <= '0;
			end
			active_q  <= '0;
			alloc_q   <= '0;
			alloc_v_q <= 1'b0;
		end else begin
			if (cmd.accept && ok) begin
				for (int i = 0; i < NUM_CHUNKS; i++) begin
					if (CW'(i) == sel_c) begin
						count_q[i] <= new_cnt;
						if (!is_alloc) head_q[i] <= block_sel;
					end
				end
				if (is_alloc && !alloc_hit) begin
					alloc_q   <= sel_c;
					alloc_v_q <= 1'b1;
					if (!scan_found) active_q <= active_q + NW'(1);
				end
			end
			// pop completes once the link read is back
			if (cmd.finish && op_alloc_s1 && ok_s1) begin
				for (int i = 0; i < NUM_CHUNKS; i++) begin
					if (CW'(i) == c_s1) head_q[i] <= rdata_q;
				end
			end
		end
	end

	// request stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_alloc_s1 <= 1'b0;
			ok_s1       <= 1'b0;
		end else if (cmd.accept) begin
			op_alloc_s1 <= is_alloc;
			ok_s1       <= ok;
		end
	end

	// request stage payload, zeroed on an error
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			st_s1  <= st;
			c_s1   <= ok ? sel_c : '0;
			b_s1   <= ok ? gb : '0;
			cnt_s1 <= ok ? new_cnt : '0;
			idx_s1 <= ok ? idx : '0;
		end
	end

	// offset multiply
	assign prod = PW'(idx_s1) * PW'(block_size);

	// response register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_st_q  <= st_s1;
			out_c_q   <= CHUNK_W'(c_s1);
			out_b_q   <= b_s1;
			out_off_q <= OFF_W'(prod);
			out_cnt_q <= cnt_s1;
		end
	end

	assign status           = out_st_q;
	assign chunk_granted    = out_c_q;
	assign block_granted    = out_b_q;
	assign byte_offset      = out_off_q;
	assign chunk_free_count = out_cnt_q;

endmodule

// ===== rtl/chunked_free_list_allocator.sv =====
// chunked_free_list_allocator: top level, config register and controller/datapath hookup
// depends on cfla_pkg, cfla_ctrl and cfla_dpath
//
//   channel   handshake               payload
//   request   in_valid / in_ready     opcode, chunk_sel, block_sel
//   response  out_valid / out_ready   status, chunk_granted, block_granted,
//                                     byte_offset, chunk_free_count
//   config    psel/penable/pwrite     paddr, pwdata, prdata (block_size at 0)
//
// one request at a time: the accept cycle chooses the chunk and issues the
// link store access, the finish cycle takes the registered link and the offset multiply
// after reset the link store init walk writes all NUM_CHUNKS*256 links (2048 at default),
// in_ready stays low until it ends; config writes are taken throughout
// a response beat not taken holds the block in its finish cycle; one request in flight
module chunked_free_list_allocator
	import cfla_pkg::*;
#(
	parameter int NUM_CHUNKS       = NUM_CHUNKS_DEF,
	parameter int BLOCKS_PER_CHUNK = BLOCKS_PER_CHUNK_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [CHUNK_W-1:0]    chunk_sel,
	input  logic [BLK_W-1:0]      block_sel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [CHUNK_W-1:0]    chunk_granted,
	output logic [BLK_W-1:0]      block_granted,
	output logic [OFF_W-1:0]      byte_offset,
	output logic [CNT_W-1:0]      chunk_free_count
);

	logic [BLK_W-1:0]     block_size_q;
	logic [REG_IDX_W-1:0] reg_idx;
	cfla_cmd_t            cmd;
	cfla_sts_t            sts;

	// config register
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign prdata  = (reg_idx == REG_BLOCK_SIZE) ? APB_DATA_W'(block_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RST;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_BLOCK_SIZE)) begin
			block_size_q <= pwdata[BLK_W-1:0];
		end
	end

	cfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	cfla_dpath #(
		.NUM_CHUNKS       (NUM_CHUNKS),
		.BLOCKS_PER_CHUNK (BLOCKS_PER_CHUNK)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.opcode           (opcode),
		.chunk_sel        (chunk_sel),
		.block_sel        (block_sel),
		.block_size       (block_size_q),
		.status           (status),
		.chunk_granted    (chunk_granted),
		.block_granted    (block_granted),
		.byte_offset      (byte_offset),
		.chunk_free_count (chunk_free_count)
	);

endmodule

// ===== rtl/cfla_checker.sv =====
// cfla_checker: port-level checks of the allocator, bound to the top level
// depends on cfla_pkg for field widths and status codes
module cfla_checker
	import cfla_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [CHUNK_W-1:0]  chunk_granted,
	input logic [BLK_W-1:0]    block_granted,
	input logic [OFF_W-1:0]    byte_offset,
	input logic [CNT_W-1:0]    chunk_free_count
);

	// a stalled response beat keeps its status, block and offset
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(block_granted) && $stable(byte_offset))
		else $error("response beat changed while stalled");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_NO_SPACE) || (status == ST_BAD_FREE))
		else $error("undefined status code");

	// error responses carry no handle
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (chunk_granted == '0) && (block_granted == '0)
			&& (byte_offset == '0) && (chunk_free_count == '0))
		else $error("error response with nonzero fields");

	// one request in flight: no accept in the cycle after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted back to back");

endmodule

bind chunked_free_list_allocator cfla_checker u_cfla_checker (.*);

// ===== tb/sv/tb_chunked_free_list_allocator.sv =====
// tb_chunked_free_list_allocator: self-checking bench for the chunked free-list allocator
// drives request beats and block_size writes, predicts every response beat and compares
// depends on cfla_pkg and chunked_free_list_allocator
module tb_chunked_free_list_allocator import cfla_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = NUM_CHUNKS_DEF;
	localparam int BPC = BLOCKS_PER_CHUNK_DEF;
	localparam logic [APB_ADDR_W-1:0] BLOCK_SIZE_ADDR = {REG_BLOCK_SIZE, 2'b00};

	typedef struct packed {
		status_t            st;
		logic [CHUNK_W-1:0] chunk;
		logic [BLK_W-1:0]   blk;
		logic [OFF_W-1:0]   off;
		logic [CNT_W-1:0]   cnt;
	} grant_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk;
		logic [BLK_W-1:0]   blk;
	} handle_t;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	// one line of the directed table; a config line carries the new block_size in blk
	typedef struct {
		row_kind_t          kind;
		opcode_t            op;
		logic [CHUNK_W-1:0] chunk;
		logic [BLK_W-1:0]   blk;
		bit                 fixed;
		grant_t             g;
	} row_t;

	localparam grant_t NO_G  = '0;
	localparam grant_t BAD_G = grant_t'{ST_BAD_FREE, 3'd0, 8'd0, 19'd0, 8'd0};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	logic                  opcode;
	logic [CHUNK_W-1:0]    chunk_sel;
	logic [BLK_W-1:0]      block_sel;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [CHUNK_W-1:0]    chunk_granted;
	logic [BLK_W-1:0]      block_granted;
	logic [OFF_W-1:0]      byte_offset;
	logic [CNT_W-1:0]      chunk_free_count;

	// allocator state as the bench sees it
	logic [BLK_W-1:0] link_mem [NCH*LINKS_PER_CHUNK];
	logic [BLK_W-1:0] head_mem [NCH];
	logic [CNT_W-1:0] count_mem [NCH];
	int               active_n;
	int               cur_chunk;
	bit               cur_valid;
	logic [7:0]       blk_bytes;

	grant_t  grant_q [$];
	handle_t live_q [$];
	row_t    dir_rows [$];
	int      err_n;
	bit      src_gaps_on;
	bit      sink_gaps_on;
	bit      sink_hold_req;

	chunked_free_list_allocator u_top (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void alloc_state_reset();
		for (int c = 0; c < NCH; c++) begin
			for (int i = 0; i < LINKS_PER_CHUNK; i++)
				link_mem[c*LINKS_PER_CHUNK + i] = BLK_W'(i + 1);
			head_mem[c] = '0;
			count_mem[c] = CNT_W'(BPC);
		end
		active_n = 0;
		cur_chunk = 0;
		cur_valid = 1'b0;
		blk_bytes = BLOCK_SIZE_RST;
	endfunction

	// expected response of one request, updating the bench's copy of the state
	function automatic grant_t alloc_predict(opcode_t op, logic [CHUNK_W-1:0] cs,
	                                         logic [BLK_W-1:0] bsel);
		grant_t      g;
		int          ch;
		int          blk;
		bit          found;
		logic [31:0] prod;
		g = NO_G;
		ch = 0;
		blk = 0;
		found = 1'b0;
		if (op == OP_ALLOC) begin
			// remembered chunk first, then the active ones in order, then a fresh one
			if (cur_valid && count_mem[cur_chunk] != 0) begin
				ch = cur_chunk;
				found = 1'b1;
			end else begin
				for (int i = 0; i < active_n; i++)
					if (!found && count_mem[i] != 0) begin
						ch = i;
						found = 1'b1;
					end
				if (!found && active_n < NCH) begin
					ch = active_n;
					active_n++;
					found = 1'b1;
				end
				if (found) begin
					cur_chunk = ch;
					cur_valid = 1'b1;
				end
			end
			if (!found) begin
				g.st = ST_NO_SPACE;
				return g;
			end
			// pop the head
			blk = head_mem[ch];
			head_mem[ch] = link_mem[ch*LINKS_PER_CHUNK + blk];
			count_mem[ch] = count_mem[ch] - 1'b1;
		end else begin
			ch = cs;
			blk = bsel;
			if (ch >= active_n || blk >= BPC || count_mem[ch] >= BPC) begin
				g.st = ST_BAD_FREE;
				return g;
			end
			// push onto the head
			link_mem[ch*LINKS_PER_CHUNK + blk] = head_mem[ch];
			head_mem[ch] = bsel;
			count_mem[ch] = count_mem[ch] + 1'b1;
		end
		prod = (ch * BPC + blk) * blk_bytes;
		g.chunk = CHUNK_W'(ch);
		g.blk = BLK_W'(blk);
		g.off = prod[OFF_W-1:0];
		g.cnt = count_mem[ch];
		return g;
	endfunction

	function automatic void add_row(row_kind_t k, opcode_t op, int cs, int bsel, bit fixed,
	                                grant_t g);
		row_t r;
		r.kind = k;
		r.op = op;
		r.chunk = CHUNK_W'(cs);
		r.blk = BLK_W'(bsel);
		r.fixed = fixed;
		r.g = g;
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			err_n++;
		end
	endfunction

	// one request beat; returns the predicted response
	task automatic send_req(input opcode_t op, input logic [CHUNK_W-1:0] cs,
	                        input logic [BLK_W-1:0] bsel, input bit fixed, input grant_t fixed_g,
	                        output grant_t pred);
		if (src_gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		chunk_sel <= cs;
		block_sel <= bsel;
		do @(posedge clk); while (!in_ready);
		pred = alloc_predict(op, cs, bsel);
		grant_q = {grant_q, fixed ? fixed_g : pred};
		if (op == OP_ALLOC && pred.st == ST_OK)
			live_q = {live_q, handle_t'{pred.chunk, pred.blk}};
		@(negedge clk);
	endtask

	// stop sending and wait for every response beat still owed
	task automatic drain();
		in_valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// block_size write followed by a read back
	task automatic cfg_block_size(input logic [7:0] v);
		logic [APB_DATA_W-1:0] rd;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= BLOCK_SIZE_ADDR;
		pwdata <= APB_DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		blk_bytes = v;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("block_size read back", v, rd[7:0]);
	endtask

	// mixed traffic: allocates, frees of blocks handed out, and stray frees
	task automatic random_item(input int alloc_pct, input int noise_pct);
		grant_t  pred;
		handle_t h;
		int      r;
		int      k;
		r = $urandom_range(0, 99);
		if (r < noise_pct) begin
			send_req(OP_FREE, CHUNK_W'($urandom_range(0, 7)), BLK_W'($urandom_range(0, 255)),
			         1'b0, NO_G, pred);
		end else if (r < noise_pct + alloc_pct || live_q.size() == 0) begin
			send_req(OP_ALLOC, CHUNK_W'($urandom), BLK_W'($urandom), 1'b0, NO_G, pred);
		end else begin
			k = $urandom_range(0, live_q.size() - 1);
			h = live_q[k];
			live_q.delete(k);
			send_req(OP_FREE, h.chunk, h.blk, 1'b0, NO_G, pred);
		end
	endtask

	// response side: random stalls, plus one long hold when asked
	initial begin
		int n;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_ready <= 1'b0;
				n = 300;
			end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 13);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 16);
			end
			repeat (n) @(negedge clk);
		end
	end

	// response checker
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grant_q.size() == 0) begin
				$display("%0t ns: response beat with none expected, status %0d", $time, status);
				err_n++;
			end else begin
				want = grant_q.pop_front();
				check_field("status", want.st, status);
				check_field("chunk_granted", want.chunk, chunk_granted);
				check_field("block_granted", want.blk, block_granted);
				check_field("byte_offset", want.off, byte_offset);
				check_field("chunk_free_count", want.cnt, chunk_free_count);
			end
		end
	end

	// stimulus
	initial begin
		grant_t pred;
		int     nospace_n;
		int     guard;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = OP_ALLOC;
		chunk_sel = '0;
		block_sel = '0;
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
		sink_hold_req = 1'b0;
		err_n = 0;
		alloc_state_reset();

		// directed table, block_size at its reset value to begin with
		// free before any chunk is active
		add_row(ROW_REQ, OP_FREE, 0, 0, 1'b1, BAD_G);
		// first allocate opens chunk 0; the chunk and block it sends are ignored
		add_row(ROW_REQ, OP_ALLOC, 7, 255, 1'b1, grant_t'{ST_OK, 3'd0, 8'd0, 19'd0, 8'd254});
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b1, grant_t'{ST_OK, 3'd0, 8'd1, 19'd16, 8'd253});
		// block index past the chunk, then a chunk never opened
		add_row(ROW_REQ, OP_FREE, 0, 255, 1'b1, BAD_G);
		add_row(ROW_REQ, OP_FREE, 7, 3, 1'b1, BAD_G);
		// give both back, then one too many into a full chunk
		add_row(ROW_REQ, OP_FREE, 0, 0, 1'b1, grant_t'{ST_OK, 3'd0, 8'd0, 19'd0, 8'd254});
		add_row(ROW_REQ, OP_FREE, 0, 1, 1'b1, grant_t'{ST_OK, 3'd0, 8'd1, 19'd16, 8'd255});
		add_row(ROW_REQ, OP_FREE, 0, 1, 1'b1, BAD_G);
		// freed blocks come back last in, first out
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b1, grant_t'{ST_OK, 3'd0, 8'd1, 19'd16, 8'd254});
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b1, grant_t'{ST_OK, 3'd0, 8'd0, 19'd0, 8'd253});
		// free of a block never handed out goes through and corrupts the list
		add_row(ROW_REQ, OP_FREE, 0, 200, 1'b0, NO_G);
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b0, NO_G);
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b0, NO_G);
		// widest block size, then the narrowest
		add_row(ROW_CFG, OP_ALLOC, 0, 255, 1'b0, NO_G);
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b0, NO_G);
		add_row(ROW_REQ, OP_FREE, 0, 254, 1'b0, NO_G);
		add_row(ROW_CFG, OP_ALLOC, 0, 1, 1'b0, NO_G);
		add_row(ROW_REQ, OP_ALLOC, 0, 0, 1'b0, NO_G);
		add_row(ROW_REQ, OP_FREE, 0, 3, 1'b0, NO_G);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				cfg_block_size(dir_rows[i].blk);
			end else begin
				send_req(dir_rows[i].op, dir_rows[i].chunk, dir_rows[i].blk, dir_rows[i].fixed,
				         dir_rows[i].g, pred);
			end
		end

		// random segments, each with its own block size
		for (int seg = 0; seg < 5; seg++) begin
			drain();
			cfg_block_size(seg == 0 ? 8'd255 : seg == 1 ? 8'd1 : 8'($urandom_range(2, 254)));
			for (int n = 0; n < 160; n++) begin
				// long response stall while requests keep coming
				if (seg == 1 && n == 40)
					sink_hold_req = 1'b1;
				// sender waits for everything in flight
				if (seg == 2 && n == 80)
					drain();
				random_item(50 + 5*seg, 6);
			end
		end

		// fill every chunk until the allocator runs dry
		drain();
		cfg_block_size(8'd255);
		nospace_n = 0;
		guard = 0;
		while (nospace_n < 4 && guard < 2500) begin
			send_req(OP_ALLOC, CHUNK_W'($urandom), BLK_W'($urandom), 1'b0, NO_G, pred);
			if (pred.st == ST_NO_SPACE)
				nospace_n++;
			guard++;
		end
		// scattered frees, then allocates that must scan back for room
		for (int n = 0; n < 40; n++)
			random_item(0, 0);
		for (int n = 0; n < 40; n++)
			random_item(100, 0);

		// closing stretch at full rate
		drain();
		cfg_block_size(8'($urandom_range(1, 255)));
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b0;
		for (int n = 0; n < 80; n++)
			random_item(40, 5);

		drain();
		repeat (20) @(posedge clk);
		if (err_n == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/cfla_pkg.sv
rtl/cfla_ctrl.sv
rtl/cfla_dpath.sv
rtl/chunked_free_list_allocator.sv
rtl/cfla_checker.sv
tb/sv/tb_chunked_free_list_allocator.sv
